>>> sv/acd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acd_pkg
// Shared types, constants and helper functions of the alarm clock with display.
// ----------------------------------------------------------------------------
package acd_pkg;

   localparam int TICKS_PER_SECOND = 1000;
   localparam int TICK_W           = $clog2(TICKS_PER_SECOND);

   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int OP_W     = 2;
   localparam int RING_W   = 16;
   localparam int BEEP_W   = 12;
   localparam int SEG_W    = 8;
   localparam int DIGIT_W  = 4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [HOUR_W-1:0]   LAST_HOUR   = HOUR_W'(23);
   localparam logic [HOUR_W-1:0]   NOON_HOUR   = HOUR_W'(12);
   localparam logic [MINUTE_W-1:0] LAST_MINUTE = MINUTE_W'(59);
   localparam logic [SECOND_W-1:0] LAST_SECOND = SECOND_W'(59);
   localparam logic [TICK_W-1:0]   LAST_TICK   = TICK_W'(TICKS_PER_SECOND - 1);

   localparam logic [RING_W-1:0] RING_LENGTH_RESET = RING_W'(5000);
   localparam logic [BEEP_W-1:0] BEEP_HALF_RESET   = BEEP_W'(500);

   localparam logic [SEG_W-1:0] SEG_BLANK   = 8'hFF;
   localparam logic [SEG_W-1:0] SEG_DOT_OFF = 8'h7F;

   typedef enum logic [OP_W-1:0] {
      OP_TICK    = 2'd0,
      OP_LOAD    = 2'd1,
      OP_SILENCE = 2'd2,
      OP_ARM     = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ALARM_HOURS   = 3'd0,
      CSR_ALARM_MINUTES = 3'd1,
      CSR_ALARM_ENABLED = 3'd2,
      CSR_TWELVE_HOUR   = 3'd3,
      CSR_RING_LENGTH   = 3'd4,
      CSR_BEEP_HALF     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [HOUR_W-1:0]   alarm_hours;
      logic [MINUTE_W-1:0] alarm_minutes;
      logic                alarm_enabled;
      logic                twelve_hour_mode;
      logic [RING_W-1:0]   ring_length_ms;
      logic [BEEP_W-1:0]   beep_half_ms;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [HOUR_W-1:0]   set_hours;
      logic [MINUTE_W-1:0] set_minutes;
   } req_item_type;

   typedef struct packed {
      logic [HOUR_W-1:0]   hours;
      logic [MINUTE_W-1:0] minutes;
      logic [SECOND_W-1:0] seconds;
      logic                buzzer_on;
      logic                alarm_ringing;
      logic                colon_on;
   } clock_state_type;

   typedef struct packed {
      logic                pm_flag;
      logic [SEG_W-1:0]    hour_tens;
      logic [SEG_W-1:0]    hour_units;
      logic [SEG_W-1:0]    minute_tens;
      logic [SEG_W-1:0]    minute_units;
   } display_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] tens;
      logic [DIGIT_W-1:0] units;
   } digit_pair_type;

   // Splits a value below 64 into decimal tens and units.
   function automatic digit_pair_type split_digits(input logic [MINUTE_W-1:0] value);
      digit_pair_type pair;
      pair.tens  = '0;
      pair.units = '0;
      priority if (value >= MINUTE_W'(60)) begin
         pair.tens  = DIGIT_W'(6);
         pair.units = DIGIT_W'(value - MINUTE_W'(60));
      end else if (value >= MINUTE_W'(50)) begin
         pair.tens  = DIGIT_W'(5);
         pair.units = DIGIT_W'(value - MINUTE_W'(50));
      end else if (value >= MINUTE_W'(40)) begin
         pair.tens  = DIGIT_W'(4);
         pair.units = DIGIT_W'(value - MINUTE_W'(40));
      end else if (value >= MINUTE_W'(30)) begin
         pair.tens  = DIGIT_W'(3);
         pair.units = DIGIT_W'(value - MINUTE_W'(30));
      end else if (value >= MINUTE_W'(20)) begin
         pair.tens  = DIGIT_W'(2);
         pair.units = DIGIT_W'(value - MINUTE_W'(20));
      end else if (value >= MINUTE_W'(10)) begin
         pair.tens  = DIGIT_W'(1);
         pair.units = DIGIT_W'(value - MINUTE_W'(10));
      end else begin
         pair.tens  = DIGIT_W'(0);
         pair.units = DIGIT_W'(value);
      end
      return pair;
   endfunction

   // Active-low seven-segment pattern of one decimal digit, dot off.
   function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] seg;
      unique case (digit)
         4'd0:    seg = 8'hC0;
         4'd1:    seg = 8'hF9;
         4'd2:    seg = 8'hA4;
         4'd3:    seg = 8'hB0;
         4'd4:    seg = 8'h99;
         4'd5:    seg = 8'h92;
         4'd6:    seg = 8'h82;
         4'd7:    seg = 8'hF8;
         4'd8:    seg = 8'h80;
         4'd9:    seg = 8'h90;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

endpackage
`default_nettype wire

>>> sv/acd_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acd_req_if
// Event channel into the clock: operation and time-load payload.
// ----------------------------------------------------------------------------
interface acd_req_if;
   logic                         valid;
   logic                         ready;
   logic [acd_pkg::OP_W-1:0]     operation;
   logic [acd_pkg::HOUR_W-1:0]   set_hours;
   logic [acd_pkg::MINUTE_W-1:0] set_minutes;

   modport source (output valid, output operation, output set_hours, output set_minutes,
                   input ready);
   modport sink   (input valid, input operation, input set_hours, input set_minutes,
                   output ready);
endinterface
`default_nettype wire

>>> sv/acd_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acd_rsp_if
// Result channel: time of day, alarm status and display segment bytes.
// ----------------------------------------------------------------------------
interface acd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [acd_pkg::HOUR_W-1:0]   hours;
   logic [acd_pkg::MINUTE_W-1:0] minutes;
   logic [acd_pkg::SECOND_W-1:0] seconds;
   logic                         buzzer_on;
   logic                         alarm_ringing;
   logic                         pm_flag;
   logic                         colon_on;
   logic [acd_pkg::SEG_W-1:0]    seg_hour_tens;
   logic [acd_pkg::SEG_W-1:0]    seg_hour_units;
   logic [acd_pkg::SEG_W-1:0]    seg_minute_tens;
   logic [acd_pkg::SEG_W-1:0]    seg_minute_units;

   modport source (output valid, output hours, output minutes, output seconds,
                   output buzzer_on, output alarm_ringing, output pm_flag, output colon_on,
                   output seg_hour_tens, output seg_hour_units, output seg_minute_tens,
                   output seg_minute_units, input ready);
   modport sink   (input valid, input hours, input minutes, input seconds,
                   input buzzer_on, input alarm_ringing, input pm_flag, input colon_on,
                   input seg_hour_tens, input seg_hour_units, input seg_minute_tens,
                   input seg_minute_units, output ready);
endinterface
`default_nettype wire

>>> sv/acd_csr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acd_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface acd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [acd_pkg::CSR_INDEX_W-1:0] index;
   logic [acd_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> sv/acd_csr_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acd_csr_regs
// Configuration registers: alarm time, enable, view mode and ring timing.
// ----------------------------------------------------------------------------
module acd_csr_regs (
   input  wire logic       clock,
   input  wire logic       reset,
   acd_csr_if.sink         csr_chan,
   output acd_pkg::cfg_type cfg
);

   acd_pkg::cfg_type cfg_ff;
   acd_pkg::cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            acd_pkg::CSR_ALARM_HOURS:
               cfg_in.alarm_hours = csr_chan.data[acd_pkg::HOUR_W-1:0];
            acd_pkg::CSR_ALARM_MINUTES:
               cfg_in.alarm_minutes = csr_chan.data[acd_pkg::MINUTE_W-1:0];
            acd_pkg::CSR_ALARM_ENABLED:
               cfg_in.alarm_enabled = csr_chan.data[0];
            acd_pkg::CSR_TWELVE_HOUR:
               cfg_in.twelve_hour_mode = csr_chan.data[0];
            acd_pkg::CSR_RING_LENGTH:
               cfg_in.ring_length_ms = csr_chan.data[acd_pkg::RING_W-1:0];
            acd_pkg::CSR_BEEP_HALF:
               cfg_in.beep_half_ms = csr_chan.data[acd_pkg::BEEP_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alarm_hours      <= '0;
         cfg_ff.alarm_minutes    <= '0;
         cfg_ff.alarm_enabled    <= 1'b0;
         cfg_ff.twelve_hour_mode <= 1'b0;
         cfg_ff.ring_length_ms   <= acd_pkg::RING_LENGTH_RESET;
         cfg_ff.beep_half_ms     <= acd_pkg::BEEP_HALF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/acd_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acd_core
// Time-of-day counters, colon blink and alarm ring sequencer. The state is
// updated once for each beat that leaves the input register.
// ----------------------------------------------------------------------------
module acd_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire acd_pkg::req_item_type  item,
   input  wire acd_pkg::cfg_type       cfg,
   output acd_pkg::clock_state_type    next_state
);

   logic [acd_pkg::TICK_W-1:0]   tick_ff,   tick_in;
   logic [acd_pkg::SECOND_W-1:0] second_ff, second_in;
   logic [acd_pkg::MINUTE_W-1:0] minute_ff, minute_in;
   logic [acd_pkg::HOUR_W-1:0]   hour_ff,   hour_in;
   logic                         colon_ff,  colon_in;
   logic                         armed_ff,  armed_in;
   logic                         ringing_ff, ringing_in;
   logic                         silenced_ff, silenced_in;
   logic                         buzzer_ff, buzzer_in;
   logic [acd_pkg::RING_W-1:0]   ring_elapsed_ff, ring_elapsed_in;
   logic [acd_pkg::BEEP_W-1:0]   beep_elapsed_ff, beep_elapsed_in;

   logic [acd_pkg::RING_W:0]     ring_next;
   logic [acd_pkg::BEEP_W:0]     beep_next;

   assign ring_next = {1'b0, ring_elapsed_ff} + (acd_pkg::RING_W+1)'(1);
   assign beep_next = {1'b0, beep_elapsed_ff} + (acd_pkg::BEEP_W+1)'(1);

   always_comb begin
      tick_in         = tick_ff;
      second_in       = second_ff;
      minute_in       = minute_ff;
      hour_in         = hour_ff;
      colon_in        = colon_ff;
      armed_in        = armed_ff;
      ringing_in      = ringing_ff;
      silenced_in     = silenced_ff;
      buzzer_in       = buzzer_ff;
      ring_elapsed_in = ring_elapsed_ff;
      beep_elapsed_in = beep_elapsed_ff;

      unique case (acd_pkg::op_type'(item.operation))
         acd_pkg::OP_TICK: begin
            if (ringing_ff) begin
               if (ring_next > {1'b0, cfg.ring_length_ms}) begin
                  buzzer_in   = 1'b0;
                  ringing_in  = 1'b0;
                  silenced_in = 1'b0;
               end else begin
                  ring_elapsed_in = ring_next[acd_pkg::RING_W-1:0];
                  if (beep_next > {1'b0, cfg.beep_half_ms}) begin
                     beep_elapsed_in = '0;
                     buzzer_in       = silenced_ff ? 1'b0 : !buzzer_ff;
                  end else begin
                     beep_elapsed_in = beep_next[acd_pkg::BEEP_W-1:0];
                  end
               end
            end
            if (tick_ff >= acd_pkg::LAST_TICK) begin
               tick_in  = '0;
               colon_in = !colon_ff;
               if (second_ff >= acd_pkg::LAST_SECOND) begin
                  second_in = '0;
                  if (minute_ff >= acd_pkg::LAST_MINUTE) begin
                     minute_in = '0;
                     if (hour_ff >= acd_pkg::LAST_HOUR) begin
                        hour_in  = '0;
                        armed_in = 1'b1;
                     end else begin
                        hour_in = hour_ff + acd_pkg::HOUR_W'(1);
                     end
                  end else begin
                     minute_in = minute_ff + acd_pkg::MINUTE_W'(1);
                  end
               end else begin
                  second_in = second_ff + acd_pkg::SECOND_W'(1);
               end
            end else begin
               tick_in = tick_ff + acd_pkg::TICK_W'(1);
            end
         end
         acd_pkg::OP_LOAD: begin
            hour_in   = (item.set_hours > acd_pkg::LAST_HOUR) ?
                        acd_pkg::LAST_HOUR : item.set_hours;
            minute_in = (item.set_minutes > acd_pkg::LAST_MINUTE) ?
                        acd_pkg::LAST_MINUTE : item.set_minutes;
            second_in = '0;
         end
         acd_pkg::OP_SILENCE: begin
            if (ringing_ff) begin
               silenced_in = 1'b1;
               buzzer_in   = 1'b0;
            end
         end
         acd_pkg::OP_ARM: begin
            armed_in = 1'b1;
         end
         default: armed_in = armed_ff;
      endcase

      if (cfg.alarm_enabled && !ringing_in && armed_in &&
          hour_in == cfg.alarm_hours && minute_in == cfg.alarm_minutes) begin
         ringing_in      = 1'b1;
         buzzer_in       = 1'b1;
         ring_elapsed_in = '0;
         beep_elapsed_in = '0;
         armed_in        = 1'b0;
      end
   end

   assign next_state.hours         = hour_in;
   assign next_state.minutes       = minute_in;
   assign next_state.seconds       = second_in;
   assign next_state.buzzer_on     = buzzer_in;
   assign next_state.alarm_ringing = ringing_in;
   assign next_state.colon_on      = colon_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff         <= '0;
         second_ff       <= '0;
         minute_ff       <= '0;
         hour_ff         <= '0;
         colon_ff        <= 1'b0;
         armed_ff        <= 1'b0;
         ringing_ff      <= 1'b0;
         silenced_ff     <= 1'b0;
         buzzer_ff       <= 1'b0;
         ring_elapsed_ff <= '0;
         beep_elapsed_ff <= '0;
      end else if (advance) begin
         tick_ff         <= tick_in;
         second_ff       <= second_in;
         minute_ff       <= minute_in;
         hour_ff         <= hour_in;
         colon_ff        <= colon_in;
         armed_ff        <= armed_in;
         ringing_ff      <= ringing_in;
         silenced_ff     <= silenced_in;
         buzzer_ff       <= buzzer_in;
         ring_elapsed_ff <= ring_elapsed_in;
         beep_elapsed_ff <= beep_elapsed_in;
      end
   end

   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      hour_ff <= acd_pkg::LAST_HOUR && minute_ff <= acd_pkg::LAST_MINUTE &&
      second_ff <= acd_pkg::LAST_SECOND && tick_ff <= acd_pkg::LAST_TICK)
      else $error("time counters out of range");

   a_buzzer_needs_ring: assert property (@(posedge clock) disable iff (reset)
      buzzer_ff |-> ringing_ff)
      else $error("buzzer driven outside a ring period");

   a_silence_needs_ring: assert property (@(posedge clock) disable iff (reset)
      silenced_ff |-> ringing_ff)
      else $error("silenced flag set outside a ring period");

   a_ring_start_disarms: assert property (@(posedge clock) disable iff (reset)
      $rose(ringing_ff) |-> !armed_ff && buzzer_ff)
      else $error("ring started without disarming or sounding");

endmodule
`default_nettype wire

>>> sv/acd_display.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acd_display
// HH:MM seven-segment encoder with 12/24-hour view, pm dot and colon dot.
// ----------------------------------------------------------------------------
module acd_display (
   input  wire acd_pkg::clock_state_type state,
   input  wire logic                     twelve_hour_mode,
   output acd_pkg::display_type          display
);

   logic [acd_pkg::HOUR_W-1:0] shown_hour;
   logic                       pm;
   acd_pkg::digit_pair_type    hour_digits;
   acd_pkg::digit_pair_type    minute_digits;
   logic [acd_pkg::SEG_W-1:0]  hour_units_seg;
   logic [acd_pkg::SEG_W-1:0]  minute_units_seg;

   always_comb begin
      shown_hour = state.hours;
      pm         = 1'b0;
      if (twelve_hour_mode) begin
         if (state.hours == '0) begin
            shown_hour = acd_pkg::NOON_HOUR;
         end else if (state.hours >= acd_pkg::NOON_HOUR) begin
            pm = 1'b1;
            if (state.hours > acd_pkg::NOON_HOUR) begin
               shown_hour = state.hours - acd_pkg::NOON_HOUR;
            end
         end
      end
   end

   assign hour_digits   = acd_pkg::split_digits({1'b0, shown_hour});
   assign minute_digits = acd_pkg::split_digits(state.minutes);

   assign hour_units_seg   = acd_pkg::seg_of(hour_digits.units);
   assign minute_units_seg = acd_pkg::seg_of(minute_digits.units);

   assign display.pm_flag      = pm;
   assign display.hour_tens    = acd_pkg::seg_of(hour_digits.tens);
   assign display.hour_units   = state.colon_on ? (hour_units_seg & acd_pkg::SEG_DOT_OFF)
                                                : hour_units_seg;
   assign display.minute_tens  = acd_pkg::seg_of(minute_digits.tens);
   assign display.minute_units = pm ? (minute_units_seg & acd_pkg::SEG_DOT_OFF)
                                    : minute_units_seg;

endmodule
`default_nettype wire

>>> sv/alarm_clock_with_display.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alarm_clock_with_display
// 24-hour alarm clock driven by millisecond tick beats, with an HH:MM
// seven-segment view of every updated time.
//
//   channel   direction  payload
//   req_chan  in         operation, set_hours, set_minutes
//   rsp_chan  out        time, buzzer/ring status, pm and colon, four segment bytes
//   csr_chan  in         register index, write data
//
// Each request beat gives one response beat via the input and result registers.
// A new request is taken every cycle while the response is not stalled; the input
// register and the result register form a two-stage pipeline and the clock state
// updates as a beat leaves the input register. Synchronous reset clears time and
// alarm state and loads default ring timing. A stalled response holds both stages.
// ----------------------------------------------------------------------------
module alarm_clock_with_display (
   input  wire logic clock,
   input  wire logic reset,
   acd_req_if.sink   req_chan,
   acd_rsp_if.source rsp_chan,
   acd_csr_if.sink   csr_chan
);

   acd_pkg::cfg_type         cfg;
   acd_pkg::req_item_type    item_ff;
   logic                     item_valid_ff;
   logic                     advance;
   acd_pkg::clock_state_type next_state;
   acd_pkg::display_type     display;
   acd_pkg::clock_state_type rsp_state_ff;
   acd_pkg::display_type     rsp_display_ff;
   logic                     rsp_valid_ff;

   assign advance        = item_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !item_valid_ff || advance;

   acd_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   acd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (item_ff),
      .cfg        (cfg),
      .next_state (next_state)
   );

   acd_display u_display (
      .state            (next_state),
      .twelve_hour_mode (cfg.twelve_hour_mode),
      .display          (display)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         item_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff.operation   <= req_chan.operation;
         item_ff.set_hours   <= req_chan.set_hours;
         item_ff.set_minutes <= req_chan.set_minutes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_state_ff   <= next_state;
         rsp_display_ff <= display;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.hours            = rsp_state_ff.hours;
   assign rsp_chan.minutes          = rsp_state_ff.minutes;
   assign rsp_chan.seconds          = rsp_state_ff.seconds;
   assign rsp_chan.buzzer_on        = rsp_state_ff.buzzer_on;
   assign rsp_chan.alarm_ringing    = rsp_state_ff.alarm_ringing;
   assign rsp_chan.colon_on         = rsp_state_ff.colon_on;
   assign rsp_chan.pm_flag          = rsp_display_ff.pm_flag;
   assign rsp_chan.seg_hour_tens    = rsp_display_ff.hour_tens;
   assign rsp_chan.seg_hour_units   = rsp_display_ff.hour_units;
   assign rsp_chan.seg_minute_tens  = rsp_display_ff.minute_tens;
   assign rsp_chan.seg_minute_units = rsp_display_ff.minute_units;

   a_advance_needs_item: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed beat did not reach the result register");

   a_no_take_when_blocked: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request taken while both stages are held");

   a_stalled_result_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> $stable(rsp_state_ff) && $stable(rsp_display_ff))
      else $error("held result changed");

endmodule
`default_nettype wire
